@@ rtl/ffa_pkg.sv @@
// Shared constants for the first-fit block allocator: field widths, command
// and status codes, register indexes. No dependencies.
package ffa_pkg;

  localparam int START_W    = 17;  // granule index of a block header
  localparam int SIZE_W     = 17;  // payload size in granules
  localparam int G_W        = 29;  // rounded request in granules
  localparam int WIDE_W     = 30;  // heap end and growth arithmetic
  localparam int ADDR_W     = 20;  // payload byte offset
  localparam int GSHIFT     = 4;   // log2 of the granule size in bytes
  localparam int LIMIT_W    = 17;
  localparam int STEP_W     = 13;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 3;

  localparam logic [LIMIT_W-1:0] HEAP_GRANULES = 17'd65536;
  localparam logic [LIMIT_W-1:0] ADDR_LAST     = 17'd65535;  // last granule the address reaches

  localparam logic [2:0] MODE_ALLOC  = 3'd0;
  localparam logic [2:0] MODE_FREE   = 3'd1;
  localparam logic [2:0] MODE_RESIZE = 3'd2;
  localparam logic [2:0] MODE_ZALLOC = 3'd3;
  localparam logic [2:0] MODE_QUERY  = 3'd4;

  localparam logic [2:0] ST_ADDR    = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_OOM     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  localparam logic REG_HEAP_LIMIT  = 1'b0;
  localparam logic REG_GROWTH_STEP = 1'b1;

endpackage

@@ rtl/ffa_in_if.sv @@
// Command channel of the allocator: valid/ready plus command fields.
// Depends on nothing.
interface ffa_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] request_bytes;
  logic [31:0] element_count;
  logic [19:0] block_addr;
  logic        addr_is_null;

  modport source (output valid, mode, request_bytes, element_count, block_addr,
                  addr_is_null, input ready);
  modport sink   (input valid, mode, request_bytes, element_count, block_addr,
                  addr_is_null, output ready);
endinterface

@@ rtl/ffa_out_if.sv @@
// Result channel of the allocator: valid/ready plus result fields.
// Depends on nothing.
interface ffa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [19:0] result_addr;
  logic [19:0] usable_bytes;

  modport source (output valid, status, result_addr, usable_bytes, input ready);
  modport sink   (input valid, status, result_addr, usable_bytes, output ready);
endinterface

@@ rtl/ffa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/first_fit_block_allocator.sv @@
// First-fit heap block allocator: sequencer over a block table in one RAM.
// Depends on ffa_pkg, ffa_in_if, ffa_out_if and ffa_ram.
//
//  channel  | direction | transfer when            | carries
//  ---------+-----------+--------------------------+-----------------------------
//  in_ch    | in        | valid && ready           | mode, request, count, address
//  out_ch   | out       | valid && ready           | status, address, usable bytes
//  APB      | in        | psel && penable && pwrite| heap_limit, growth_step
//
// A command's table walk reads one linked entry per cycle through the RAM read port,
// and a growing resize walks twice, once to find the block and once to place the
// new one. Splits, appends and free marks then follow, one RAM write each.
// Synchronous active-low reset empties the heap at once; the table needs no clearing.
// in_ch.ready is high only between commands; a result held on out_ch stalls
// the next result, not the next command's acceptance.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  ffa_in_if.sink      in_ch,
  ffa_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [ffa_pkg::PADDR_W-1:0] paddr,
  input  logic [ffa_pkg::DATA_W-1:0]  pwdata,
  output logic [ffa_pkg::DATA_W-1:0]  prdata,
  output logic        pready
);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  typedef struct packed {
    logic [ffa_pkg::START_W-1:0] start;
    logic [ffa_pkg::SIZE_W-1:0]  size;
    logic                        free;
    logic [IW-1:0]               nxt;
  } entry_t;
  localparam int EW = $bits(entry_t);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_PREP    = 12'b000000000010,
    S_START   = 12'b000000000100,
    S_WALK    = 12'b000000001000,
    S_SPLIT2  = 12'b000000010000,
    S_GROW    = 12'b000000100000,
    S_GROW2   = 12'b000001000000,
    S_GROW3   = 12'b000010000000,
    S_APPEND2 = 12'b000100000000,
    S_FSET_RD = 12'b001000000000,
    S_FSET_WR = 12'b010000000000,
    S_RESP    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic find_r, find_nxt, grow_r, grow_nxt;
  logic [2:0]  mode_r;
  logic        null_r;
  logic [19:0] addr_r;
  logic [31:0] req_r;
  logic        zero_r;
  logic [63:0] prod_r;
  logic [ffa_pkg::G_W-1:0] g_r, g_nxt;
  logic [IW-1:0] idx_r, idx_nxt, slot_r, slot_nxt, knew_r, knew_nxt;
  logic [IW-1:0] tidx_r, tidx_nxt, pidx_r, pidx_nxt;
  entry_t tail_r, tail_nxt, pend_r, pend_nxt;
  logic [ffa_pkg::WIDE_W-1:0] end_r, end_nxt, inc_r, inc_nxt, nt_r, nt_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [ffa_pkg::LIMIT_W-1:0] top_r, top_nxt, used_r, used_nxt, limit_r;
  logic [ffa_pkg::STEP_W-1:0]  step_r;
  logic [2:0]  res_stat_r, res_stat_nxt;
  logic [19:0] res_addr_r, res_addr_nxt, res_use_r, res_use_nxt;
  logic        ov_r, ov_nxt, load;
  logic [2:0]  o_stat_r;
  logic [19:0] o_addr_r, o_use_r;

  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  ffa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // walk compare unit
  entry_t e;
  logic [ffa_pkg::START_W:0]   e_end;
  logic                        tail_hit, fits, can_split, is_match;
  logic [ffa_pkg::SIZE_W-1:0]  diff;
  logic [ffa_pkg::START_W-1:0] e_s1;
  entry_t split_e, keep_e;
  logic [15:0] gran;
  logic [32:0] gsum;
  logic [31:0] gsel;
  logic        aligned, cnt_room;
  logic [ffa_pkg::WIDE_W-1:0] nt_sum;
  logic [ffa_pkg::LIMIT_W-1:0] lim;

  assign e        = entry_t'(ram_rdata);
  assign e_end    = {1'b0, e.start} + 18'd1 + {1'b0, e.size};
  assign tail_hit = e_end == {1'b0, used_r};
  assign fits     = e.free && (ffa_pkg::G_W'(e.size) >= g_r);
  assign diff     = e.size - g_r[ffa_pkg::SIZE_W-1:0];
  assign cnt_room = cnt_r < CW'(MAX_BLOCKS);
  assign can_split = (diff >= 17'd2) && cnt_room;
  assign e_s1     = e.start + 17'd1;
  assign gran     = addr_r[19:4] - 16'd1;
  assign is_match = e.start == {1'b0, gran};
  assign aligned  = (addr_r[3:0] == 4'd0) && (addr_r[19:4] != 16'd0);
  assign gsel     = (mode_r == ffa_pkg::MODE_ZALLOC) ? prod_r[31:0] : req_r;
  assign gsum     = {1'b0, gsel} + 33'd15;
  assign nt_sum   = ffa_pkg::WIDE_W'(top_r) + inc_r;
  assign lim      = (limit_r < ffa_pkg::HEAP_GRANULES) ? limit_r : ffa_pkg::HEAP_GRANULES;

  always_comb begin
    split_e.start = e_s1 + g_r[ffa_pkg::START_W-1:0];
    split_e.size  = diff - 17'd1;
    split_e.free  = 1'b1;
    split_e.nxt   = e.nxt;
    keep_e.start  = e.start;
    keep_e.size   = g_r[ffa_pkg::SIZE_W-1:0];
    keep_e.free   = 1'b0;
    keep_e.nxt    = cnt_r[IW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    find_nxt = find_r;
    grow_nxt = grow_r;
    g_nxt = g_r;
    idx_nxt = idx_r;
    slot_nxt = slot_r;
    knew_nxt = knew_r;
    tidx_nxt = tidx_r;
    pidx_nxt = pidx_r;
    tail_nxt = tail_r;
    pend_nxt = pend_r;
    end_nxt = end_r;
    inc_nxt = inc_r;
    nt_nxt = nt_r;
    cnt_nxt = cnt_r;
    top_nxt = top_r;
    used_nxt = used_r;
    res_stat_nxt = res_stat_r;
    res_addr_nxt = res_addr_r;
    res_use_nxt = res_use_r;
    ram_we = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    load = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        g_nxt = gsum[32:4];
        grow_nxt = 1'b0;
        find_nxt = 1'b0;
        res_stat_nxt = ffa_pkg::ST_INVALID;
        res_addr_nxt = '0;
        res_use_nxt = '0;
        state_nxt = S_RESP;
        case (mode_r)
          ffa_pkg::MODE_ALLOC: state_nxt = S_START;
          ffa_pkg::MODE_ZALLOC: begin
            if (!zero_r && prod_r[63:32] == 32'd0) begin
              state_nxt = S_START;
            end
          end
          ffa_pkg::MODE_FREE, ffa_pkg::MODE_QUERY, ffa_pkg::MODE_RESIZE: begin
            if (null_r) begin
              if (mode_r == ffa_pkg::MODE_RESIZE) begin
                state_nxt = S_START;
              end else begin
                res_stat_nxt = ffa_pkg::ST_DONE;
              end
            end else if (!aligned || cnt_r == '0) begin
              res_stat_nxt = ffa_pkg::ST_UNKNOWN;
            end else begin
              find_nxt = 1'b1;
              state_nxt = S_START;
            end
          end
          default: state_nxt = S_RESP;
        endcase
      end
      S_START: begin
        idx_nxt = '0;
        state_nxt = (cnt_r == '0) ? S_GROW : S_WALK;
      end
      S_WALK: begin
        ram_raddr = e.nxt;
        idx_nxt = e.nxt;
        pidx_nxt = idx_r;
        if (find_r) begin
          if (is_match) begin
            slot_nxt = idx_r;
            state_nxt = S_RESP;
            case (mode_r)
              ffa_pkg::MODE_FREE: begin
                ram_we = 1'b1;
                ram_wdata = {e.start, e.size, 1'b1, e.nxt};
                res_stat_nxt = ffa_pkg::ST_DONE;
              end
              ffa_pkg::MODE_QUERY: begin
                res_stat_nxt = ffa_pkg::ST_DONE;
                res_use_nxt = {e.size[15:0], 4'd0};
              end
              ffa_pkg::MODE_RESIZE: begin
                if (e.free) begin
                  res_stat_nxt = ffa_pkg::ST_UNKNOWN;
                end else if (g_r == '0) begin
                  ram_we = 1'b1;
                  ram_wdata = {e.start, e.size, 1'b1, e.nxt};
                  res_stat_nxt = ffa_pkg::ST_DONE;
                end else if (g_r > ffa_pkg::G_W'(e.size)) begin
                  grow_nxt = 1'b1;
                  find_nxt = 1'b0;
                  state_nxt = S_START;
                end else begin
                  res_stat_nxt = ffa_pkg::ST_ADDR;
                  res_addr_nxt = {e_s1[15:0], 4'd0};
                  if (can_split) begin
                    ram_we = 1'b1;
                    ram_waddr = cnt_r[IW-1:0];
                    ram_wdata = split_e;
                    pend_nxt = keep_e;
                    cnt_nxt = cnt_r + 1'b1;
                    res_use_nxt = {g_r[15:0], 4'd0};
                    state_nxt = S_SPLIT2;
                  end else begin
                    res_use_nxt = {e.size[15:0], 4'd0};
                  end
                end
              end
              default: state_nxt = S_RESP;
            endcase
          end else if (tail_hit) begin
            res_stat_nxt = ffa_pkg::ST_UNKNOWN;
            state_nxt = S_RESP;
          end
        end else begin
          if (fits) begin
            res_stat_nxt = ffa_pkg::ST_ADDR;
            res_addr_nxt = {e_s1[15:0], 4'd0};
            if (can_split) begin
              ram_we = 1'b1;
              ram_waddr = cnt_r[IW-1:0];
              ram_wdata = split_e;
              pend_nxt = keep_e;
              cnt_nxt = cnt_r + 1'b1;
              res_use_nxt = {g_r[15:0], 4'd0};
              state_nxt = S_SPLIT2;
            end else begin
              ram_we = 1'b1;
              ram_wdata = {e.start, e.size, 1'b0, e.nxt};
              res_use_nxt = {e.size[15:0], 4'd0};
              state_nxt = grow_r ? S_FSET_RD : S_RESP;
            end
          end else if (tail_hit) begin
            tail_nxt = e;
            tidx_nxt = idx_r;
            state_nxt = S_GROW;
          end
        end
      end
      S_SPLIT2: begin
        ram_we = 1'b1;
        ram_waddr = pidx_r;
        ram_wdata = pend_r;
        state_nxt = grow_r ? S_FSET_RD : S_RESP;
      end
      S_GROW: begin
        end_nxt = ffa_pkg::WIDE_W'(used_r) + 30'd1 + ffa_pkg::WIDE_W'(g_r);
        inc_nxt = (ffa_pkg::WIDE_W'(step_r) > ffa_pkg::WIDE_W'(g_r) + 30'd1)
                  ? ffa_pkg::WIDE_W'(step_r) : ffa_pkg::WIDE_W'(g_r) + 30'd1;
        if (!cnt_room || used_r >= ffa_pkg::ADDR_LAST) begin
          res_stat_nxt = ffa_pkg::ST_OOM;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_GROW2;
        end
      end
      S_GROW2: begin
        nt_nxt = (nt_sum > ffa_pkg::WIDE_W'(lim)) ? ffa_pkg::WIDE_W'(lim) : nt_sum;
        state_nxt = S_GROW3;
      end
      S_GROW3: begin
        if (end_r > ffa_pkg::WIDE_W'(top_r) && end_r > nt_r) begin
          res_stat_nxt = ffa_pkg::ST_OOM;
          state_nxt = S_RESP;
        end else begin
          if (end_r > ffa_pkg::WIDE_W'(top_r)) begin
            top_nxt = nt_r[ffa_pkg::LIMIT_W-1:0];
          end
          ram_we = 1'b1;
          ram_waddr = cnt_r[IW-1:0];
          ram_wdata = {used_r, g_r[ffa_pkg::SIZE_W-1:0], 1'b0, cnt_r[IW-1:0]};
          knew_nxt = cnt_r[IW-1:0];
          cnt_nxt = cnt_r + 1'b1;
          used_nxt = end_r[ffa_pkg::LIMIT_W-1:0];
          res_stat_nxt = ffa_pkg::ST_ADDR;
          res_addr_nxt = {used_r[15:0] + 16'd1, 4'd0};
          res_use_nxt = {g_r[15:0], 4'd0};
          if (cnt_r != '0) begin
            state_nxt = S_APPEND2;
          end else begin
            state_nxt = grow_r ? S_FSET_RD : S_RESP;
          end
        end
      end
      S_APPEND2: begin
        // link the old tail to the appended block
        ram_we = 1'b1;
        ram_waddr = tidx_r;
        ram_wdata = {tail_r.start, tail_r.size, tail_r.free, knew_r};
        state_nxt = grow_r ? S_FSET_RD : S_RESP;
      end
      S_FSET_RD: begin
        ram_raddr = slot_r;
        state_nxt = S_FSET_WR;
      end
      S_FSET_WR: begin
        ram_we = 1'b1;
        ram_waddr = slot_r;
        ram_wdata = {e.start, e.size, 1'b1, e.nxt};
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!ov_r || out_ch.ready) begin
          load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r && !out_ch.ready;
    if (load) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      top_r   <= '0;
      used_r  <= '0;
      ov_r    <= 1'b0;
      limit_r <= ffa_pkg::HEAP_GRANULES;
      step_r  <= 13'd256;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      top_r   <= top_nxt;
      used_r  <= used_nxt;
      ov_r    <= ov_nxt;
      if (psel && penable && pwrite) begin
        if (paddr[2] == ffa_pkg::REG_GROWTH_STEP) begin
          step_r <= pwdata[ffa_pkg::STEP_W-1:0];
        end else begin
          limit_r <= pwdata[ffa_pkg::LIMIT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      mode_r <= in_ch.mode;
      null_r <= in_ch.addr_is_null;
      addr_r <= in_ch.block_addr;
      req_r  <= in_ch.request_bytes;
      zero_r <= (in_ch.request_bytes == 32'd0) || (in_ch.element_count == 32'd0);
      prod_r <= 64'(in_ch.request_bytes) * 64'(in_ch.element_count);
    end
    find_r <= find_nxt;
    grow_r <= grow_nxt;
    g_r    <= g_nxt;
    idx_r  <= idx_nxt;
    slot_r <= slot_nxt;
    knew_r <= knew_nxt;
    tidx_r <= tidx_nxt;
    pidx_r <= pidx_nxt;
    tail_r <= tail_nxt;
    pend_r <= pend_nxt;
    end_r  <= end_nxt;
    inc_r  <= inc_nxt;
    nt_r   <= nt_nxt;
    res_stat_r <= res_stat_nxt;
    res_addr_r <= res_addr_nxt;
    res_use_r  <= res_use_nxt;
    if (load) begin
      o_stat_r <= res_stat_r;
      o_addr_r <= res_addr_r;
      o_use_r  <= res_use_r;
    end
  end

  assign in_ch.ready         = state_r == S_IDLE;
  assign out_ch.valid        = ov_r;
  assign out_ch.status       = o_stat_r;
  assign out_ch.result_addr  = o_addr_r;
  assign out_ch.usable_bytes = o_use_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ffa_pkg::REG_GROWTH_STEP)
                  ? ffa_pkg::DATA_W'(step_r) : ffa_pkg::DATA_W'(limit_r);
endmodule

@@ verif/ffa_checker.sv @@
// Checker for the first-fit block allocator: watches the command, result and
// register ports, predicts each result and compares. Depends on ffa_pkg and the
// ffa_in_if / ffa_out_if interfaces.
module ffa_checker #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  ffa_in_if          in_ch,
  ffa_out_if         out_ch,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic       pready,
  input  logic [ffa_pkg::PADDR_W-1:0] paddr,
  input  logic [ffa_pkg::DATA_W-1:0]  pwdata,
  output int         fail_count,
  output int         pending,
  output int         cmd_count,
  output int         result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ADDR_GRANS = 1048576 / 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] addr;
    logic [19:0] bytes;
  } alloc_result_t;

  alloc_result_t expected_q[$];

  longint blk_start [MAX_BLOCKS];
  longint blk_size  [MAX_BLOCKS];
  bit     blk_free  [MAX_BLOCKS];
  int     blk_next  [MAX_BLOCKS];
  int     blk_count;
  longint top_gran;
  longint end_gran;
  longint limit_gran;
  longint step_gran;

  function automatic bit ends_heap(int i);
    return blk_start[i] + 1 + blk_size[i] == end_gran;
  endfunction

  function automatic void split_tail(int idx, longint g);
    longint diff;
    int k;
    diff = blk_size[idx] - g;
    if (diff >= 2 && blk_count < MAX_BLOCKS) begin
      k = blk_count++;
      blk_start[k] = blk_start[idx] + 1 + g;
      blk_size[k]  = diff - 1;
      blk_free[k]  = 1'b1;
      blk_next[k]  = blk_next[idx];
      blk_next[idx] = k;
      blk_size[idx] = g;
    end
  endfunction

  function automatic bit take_granules(longint g, output int slot);
    int idx, tail, k;
    longint fin, lim, inc, nt;
    idx = 0;
    tail = 0;
    slot = 0;
    for (int n = 0; n < blk_count; n++) begin
      if (idx >= MAX_BLOCKS) break;
      if (blk_free[idx] && blk_size[idx] >= g) begin
        split_tail(idx, g);
        blk_free[idx] = 1'b0;
        slot = idx;
        return 1'b1;
      end
      tail = idx;
      if (ends_heap(idx)) break;
      idx = blk_next[idx];
    end
    if (blk_count >= MAX_BLOCKS) return 1'b0;
    if (end_gran + 1 >= ADDR_GRANS) return 1'b0;
    fin = end_gran + 1 + g;
    if (fin > top_gran) begin
      lim = (limit_gran < 65536) ? limit_gran : 65536;
      inc = (step_gran > g + 1) ? step_gran : g + 1;
      nt = top_gran + inc;
      if (nt > lim) nt = lim;
      if (fin > nt) return 1'b0;
      top_gran = nt;
    end
    k = blk_count;
    blk_start[k] = end_gran;
    blk_size[k]  = g;
    blk_free[k]  = 1'b0;
    blk_next[k]  = k;
    if (blk_count > 0) blk_next[tail] = k;
    blk_count++;
    end_gran = fin;
    slot = k;
    return 1'b1;
  endfunction

  function automatic bit lookup_block(logic [19:0] addr, output int slot);
    int idx;
    longint gran;
    idx = 0;
    slot = 0;
    if (addr[3:0] != 4'd0 || addr < 20'd16) return 1'b0;
    gran = longint'(addr >> 4) - 1;
    for (int n = 0; n < blk_count; n++) begin
      if (idx >= MAX_BLOCKS) return 1'b0;
      if (blk_start[idx] == gran) begin
        slot = idx;
        return 1'b1;
      end
      if (ends_heap(idx)) return 1'b0;
      idx = blk_next[idx];
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t block_result(int slot);
    alloc_result_t r;
    longint a, b;
    a = (blk_start[slot] + 1) * 16;
    b = blk_size[slot] * 16;
    r.status = ffa_pkg::ST_ADDR;
    r.addr   = a[19:0];
    r.bytes  = b[19:0];
    return r;
  endfunction

  function automatic alloc_result_t place(longint nbytes);
    alloc_result_t r;
    int slot;
    r = '0;
    if (take_granules((nbytes + 15) / 16, slot)) r = block_result(slot);
    else r.status = ffa_pkg::ST_OOM;
    return r;
  endfunction

  function automatic alloc_result_t run_command(logic [2:0] mode, logic [31:0] req_b,
                                                logic [31:0] cnt, logic [19:0] addr,
                                                logic is_null);
    alloc_result_t r;
    longint req, g, prod, b;
    int slot, fresh;
    r = '0;
    r.status = ffa_pkg::ST_INVALID;
    req = longint'(req_b);
    g = (req + 15) / 16;
    case (mode)
      ffa_pkg::MODE_ALLOC: r = place(req);
      ffa_pkg::MODE_FREE: begin
        if (is_null) r.status = ffa_pkg::ST_DONE;
        else if (lookup_block(addr, slot)) begin
          blk_free[slot] = 1'b1;
          r.status = ffa_pkg::ST_DONE;
        end else r.status = ffa_pkg::ST_UNKNOWN;
      end
      ffa_pkg::MODE_RESIZE: begin
        if (is_null) r = place(req);
        else if (!lookup_block(addr, slot) || blk_free[slot])
          r.status = ffa_pkg::ST_UNKNOWN;
        else if (g == 0) begin
          blk_free[slot] = 1'b1;
          r.status = ffa_pkg::ST_DONE;
        end else if (g > blk_size[slot]) begin
          if (take_granules(g, fresh)) begin
            blk_free[slot] = 1'b1;
            r = block_result(fresh);
          end else r.status = ffa_pkg::ST_OOM;
        end else begin
          split_tail(slot, g);
          r = block_result(slot);
        end
      end
      ffa_pkg::MODE_ZALLOC: begin
        prod = req * longint'(cnt);
        if (req == 0 || cnt == 0 || prod > 64'hFFFF_FFFF) r.status = ffa_pkg::ST_INVALID;
        else r = place(prod);
      end
      ffa_pkg::MODE_QUERY: begin
        if (is_null) r.status = ffa_pkg::ST_DONE;
        else if (lookup_block(addr, slot)) begin
          b = blk_size[slot] * 16;
          r.status = ffa_pkg::ST_DONE;
          r.bytes = b[19:0];
        end else r.status = ffa_pkg::ST_UNKNOWN;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    alloc_result_t got, want;
    if (!rst_n) begin
      expected_q.delete();
      blk_count = 0;
      top_gran = 0;
      end_gran = 0;
      limit_gran = 65536;
      step_gran = 256;
      fail_count <= 0;
      cmd_count <= 0;
      result_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == ffa_pkg::REG_HEAP_LIMIT) limit_gran = longint'(pwdata[16:0]);
        else step_gran = longint'(pwdata[12:0]);
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(run_command(in_ch.mode, in_ch.request_bytes,
                                         in_ch.element_count, in_ch.block_addr,
                                         in_ch.addr_is_null));
        cmd_count <= cmd_count + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status = out_ch.status;
        got.addr   = out_ch.result_addr;
        got.bytes  = out_ch.usable_bytes;
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("mismatch: result with nothing expected: status %0d addr %h bytes %0d",
                     got.status, got.addr, got.bytes);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("mismatch: expected status %0d addr %h bytes %0d, got %0d %h %0d",
                       want.status, want.addr, want.bytes, got.status, got.addr,
                       got.bytes);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ verif/testbench.sv @@
// Top of the allocator testbench: clock, reset, command and register stimulus,
// result backpressure and verdict. Depends on ffa_pkg, the channel interfaces,
// ffa_checker and first_fit_block_allocator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_CYCLES = 20000;
  localparam int SETTLE_CYCLES = 300;
  localparam logic [ffa_pkg::PADDR_W-1:0] ADDR_LIMIT = {ffa_pkg::REG_HEAP_LIMIT, 2'b00};
  localparam logic [ffa_pkg::PADDR_W-1:0] ADDR_STEP  = {ffa_pkg::REG_GROWTH_STEP, 2'b00};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ffa_pkg::PADDR_W-1:0] paddr = '0;
  logic [ffa_pkg::DATA_W-1:0] pwdata = '0;
  logic [ffa_pkg::DATA_W-1:0] prdata;
  logic pready;
  int fail_count, pending, cmd_count, result_count;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;
  logic [19:0] live_addrs[$];

  ffa_in_if  in_ch();
  ffa_out_if out_ch();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = ffa_pkg::MODE_ALLOC;
    in_ch.request_bytes = '0;
    in_ch.element_count = '0;
    in_ch.block_addr = '0;
    in_ch.addr_is_null = 1'b0;
    out_ch.ready = 1'b0;
  end

  always #5 clk = ~clk;

  first_fit_block_allocator i_dut (
    .clk, .rst_n, .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ffa_checker i_checker (
    .clk, .rst_n, .in_ch, .out_ch, .psel, .penable, .pwrite, .pready, .paddr,
    .pwdata, .fail_count, .pending, .cmd_count, .result_count
  );

  // Remember granted payload addresses so later commands hit real blocks.
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready && out_ch.status == ffa_pkg::ST_ADDR) begin
      live_addrs.push_back(out_ch.result_addr);
      if (live_addrs.size() > 64) void'(live_addrs.pop_front());
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("FAIL first_fit_block_allocator");
      $finish;
    end
  end

  // Result backpressure: stall a random number of cycles before each transfer.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      n = no_gaps ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  task automatic reg_write(logic [ffa_pkg::PADDR_W-1:0] a, logic [ffa_pkg::DATA_W-1:0] d);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send(logic [2:0] mode, logic [31:0] req, logic [31:0] cnt,
                      logic [19:0] addr, logic is_null);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.request_bytes <= req;
    in_ch.element_count <= cnt;
    in_ch.block_addr <= addr;
    in_ch.addr_is_null <= is_null;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold off until every result is back and the block has gone quiet.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [19:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (live_addrs.size() > 0 && r < 7)
      return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
    if (live_addrs.size() > 0 && r == 7)
      return live_addrs[$urandom_range(0, live_addrs.size() - 1)] + 20'd8;
    return 20'($urandom());
  endfunction

  function automatic logic [31:0] pick_bytes();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom();
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 5) return $urandom_range(0, 40);
    return $urandom_range(0, 3000);
  endfunction

  task automatic random_phase(int n);
    int r;
    logic [2:0] mode;
    logic [31:0] req, cnt;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 30) mode = ffa_pkg::MODE_ALLOC;
      else if (r < 50) mode = ffa_pkg::MODE_FREE;
      else if (r < 70) mode = ffa_pkg::MODE_RESIZE;
      else if (r < 80) mode = ffa_pkg::MODE_ZALLOC;
      else if (r < 95) mode = ffa_pkg::MODE_QUERY;
      else mode = 3'($urandom_range(5, 7));
      req = pick_bytes();
      cnt = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 20);
      if (mode == ffa_pkg::MODE_ZALLOC) req = ($urandom_range(0, 7) == 0) ? $urandom()
                                                                       : $urandom_range(0, 100);
      send(mode, req, cnt, pick_addr(), $urandom_range(0, 15) == 0);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: size edges, every command, lookup and overflow corner cases.
    send(ffa_pkg::MODE_ALLOC, 32'd0, 32'd0, 20'd0, 1'b0);
    send(ffa_pkg::MODE_ALLOC, 32'd1, 32'd0, 20'd0, 1'b0);
    send(ffa_pkg::MODE_ALLOC, 32'd100, 32'd0, 20'd0, 1'b0);
    send(ffa_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1);
    send(ffa_pkg::MODE_QUERY, 32'd0, 32'd0, 20'd16, 1'b0);
    send(ffa_pkg::MODE_QUERY, 32'd0, 32'd0, 20'd0, 1'b1);
    send(ffa_pkg::MODE_QUERY, 32'd0, 32'd0, 20'd24, 1'b0);
    send(ffa_pkg::MODE_RESIZE, 32'd20, 32'd0, 20'd48, 1'b0);
    send(ffa_pkg::MODE_RESIZE, 32'd5000, 32'd0, 20'd48, 1'b0);
    send(ffa_pkg::MODE_RESIZE, 32'd0, 32'd0, 20'd16, 1'b0);
    send(ffa_pkg::MODE_RESIZE, 32'd16, 32'd0, 20'd16, 1'b0);
    send(ffa_pkg::MODE_RESIZE, 32'd64, 32'd0, 20'd0, 1'b1);
    send(ffa_pkg::MODE_FREE, 32'd0, 32'd0, 20'd0, 1'b1);
    send(ffa_pkg::MODE_FREE, 32'd0, 32'd0, 20'd32, 1'b0);
    send(ffa_pkg::MODE_FREE, 32'd0, 32'd0, 20'd32, 1'b0);
    send(ffa_pkg::MODE_FREE, 32'd0, 32'd0, 20'hFFFF0, 1'b0);
    send(ffa_pkg::MODE_ALLOC, 32'd8, 32'd0, 20'd0, 1'b0);
    send(ffa_pkg::MODE_ZALLOC, 32'd0, 32'd5, 20'd0, 1'b0);
    send(ffa_pkg::MODE_ZALLOC, 32'd5, 32'd0, 20'd0, 1'b0);
    send(ffa_pkg::MODE_ZALLOC, 32'h0001_0000, 32'h0001_0000, 20'd0, 1'b0);
    send(ffa_pkg::MODE_ZALLOC, 32'd12, 32'd10, 20'd0, 1'b0);
    send(ffa_pkg::MODE_ZALLOC, 32'hFFFF_FFFF, 32'd1, 20'd0, 1'b0);
    send(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1);
    send(3'd6, 32'd0, 32'd0, 20'd0, 1'b0);
    send(3'd7, 32'd1, 32'd1, 20'd1, 1'b0);
    drain();

    random_phase(150);
    drain();
    reg_write(ADDR_LIMIT, 32'd1);
    reg_write(ADDR_STEP, 32'd1);
    random_phase(120);
    drain();
    reg_write(ADDR_LIMIT, 32'd65536);
    reg_write(ADDR_STEP, 32'd4096);
    random_phase(180);
    drain();
    reg_write(ADDR_LIMIT, 32'd3000);
    reg_write(ADDR_STEP, 32'd17);
    random_phase(120);
    drain();
    reg_write(ADDR_LIMIT, 32'd65536);
    reg_write(ADDR_STEP, 32'd256);
    random_phase(130);
    drain();

    $display("ran %0d commands with %0d results over four register settings,",
             cmd_count, result_count);
    $display("covering allocate, free, resize, zeroed allocate, query and bad modes");
    if (fail_count == 0) begin
      $display("PASS first_fit_block_allocator");
    end else begin
      $display("FAIL first_fit_block_allocator");
    end
    $finish;
  end
endmodule
